// ===== hw/rtl/inc_pkg.sv =====
// ----------------------------------------------------------------------------
// inc_pkg
// Shared constants and types for the inverse normal CDF pipeline.
// ----------------------------------------------------------------------------
package inc_pkg;

  localparam int PROB_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int IW        = 24;
  localparam int OUT_BITS  = FRAC_BITS + 4;
  localparam int LOD_BITS  = $clog2(PROB_BITS);
  localparam int Y_BITS    = 30;
  localparam int T_BITS    = 27;
  localparam int R_BITS    = 28;
  localparam int SQ_STEPS  = 28;
  localparam int DIV_STEPS = R_BITS;

  localparam logic [24:0] C_2LN2 = 25'd23257910;
  localparam logic [25:0] C_N0   = 26'd42203371;
  localparam logic [23:0] C_N1   = 24'd13469638;
  localparam logic [17:0] C_N2   = 18'd173275;
  localparam logic [24:0] C_D1   = 25'd24038194;
  localparam logic [21:0] C_D2   = 22'd3175407;
  localparam logic [14:0] C_D3   = 15'd21945;

  typedef struct packed {
    logic neg;
    logic zero;
    logic half;
  } side_t;

endpackage

// ===== hw/rtl/inc_log2.sv =====
// ----------------------------------------------------------------------------
// inc_log2
// Normalize the tail, run one squaring step per stage, form -log2 q in Q.24.
// ----------------------------------------------------------------------------
module inc_log2 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           vi,
  input  inc_pkg::side_t                 si,
  input  logic [inc_pkg::PROB_BITS-1:0]  x,
  output logic                           vo,
  output inc_pkg::side_t                 so,
  output logic [inc_pkg::Y_BITS-1:0]     y
);
  import inc_pkg::*;

  logic [LOD_BITS-1:0]     lod;
  logic [PROB_BITS+29:0]   nsh;
  logic                    lv [0:IW];
  side_t                   ls [0:IW];
  logic [30:0]             lm [0:IW];
  logic [LOD_BITS-1:0]     le [0:IW];
  logic [IW-1:0]           lf [0:IW];

  always_comb begin
    lod = '0;
    for (int i = 0; i < PROB_BITS; i++) begin
      if (x[i]) begin
        lod = LOD_BITS'(i);
      end
    end
  end

  assign nsh = {x, 30'b0} >> lod;

  always_ff @(posedge clk) begin
    if (rst) begin
      lv[0] <= 1'b0;
    end else if (en) begin
      lv[0] <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ls[0] <= si;
      lm[0] <= nsh[30:0];
      le[0] <= lod;
      lf[0] <= '0;
    end
  end

  for (genvar g = 0; g < IW; g++) begin : g_step
    logic [61:0] prod;
    logic [31:0] sq;
    logic [IW-1:0] fbit;
    assign prod = lm[g] * lm[g];
    assign sq   = prod[61:30];
    assign fbit = IW'(sq[31]) << (IW - 1 - g);

    always_ff @(posedge clk) begin
      if (rst) begin
        lv[g+1] <= 1'b0;
      end else if (en) begin
        lv[g+1] <= lv[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ls[g+1] <= ls[g];
        le[g+1] <= le[g];
        lm[g+1] <= sq[31] ? sq[31:1] : sq[30:0];
        lf[g+1] <= lf[g] | fbit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (en) begin
      vo <= lv[IW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      so <= ls[IW];
      y  <= ((Y_BITS'(PROB_BITS) - Y_BITS'(le[IW])) << IW) - Y_BITS'(lf[IW]);
    end
  end

endmodule

// ===== hw/rtl/inc_sqrt.sv =====
// ----------------------------------------------------------------------------
// inc_sqrt
// Scale by 2 ln 2, then a restoring square root with one result bit per stage.
// ----------------------------------------------------------------------------
module inc_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        vi,
  input  inc_pkg::side_t              si,
  input  logic [inc_pkg::Y_BITS-1:0]  y,
  output logic                        vo,
  output inc_pkg::side_t              so,
  output logic [inc_pkg::T_BITS-1:0]  t
);
  import inc_pkg::*;

  logic [Y_BITS+24:0] sp;
  logic               qv [0:SQ_STEPS];
  side_t              qs [0:SQ_STEPS];
  logic [55:0]        qr [0:SQ_STEPS];
  logic [55:0]        qres [0:SQ_STEPS];

  assign sp = y * C_2LN2;

  always_ff @(posedge clk) begin
    if (rst) begin
      qv[0] <= 1'b0;
    end else if (en) begin
      qv[0] <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qs[0]   <= si;
      qr[0]   <= {2'b0, sp[IW+Y_BITS-1:IW], 24'b0};
      qres[0] <= '0;
    end
  end

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
    logic [55:0] bitv;
    logic [55:0] sum;
    logic        ge;
    assign bitv = 56'(1) << (2 * (SQ_STEPS - 1 - g));
    assign sum  = qres[g] + bitv;
    assign ge   = qr[g] >= sum;

    always_ff @(posedge clk) begin
      if (rst) begin
        qv[g+1] <= 1'b0;
      end else if (en) begin
        qv[g+1] <= qv[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qs[g+1]   <= qs[g];
        qr[g+1]   <= ge ? (qr[g] - sum) : qr[g];
        qres[g+1] <= ge ? ((qres[g] >> 1) + bitv) : (qres[g] >> 1);
      end
    end
  end

  assign vo = qv[SQ_STEPS];
  assign so = qs[SQ_STEPS];
  assign t  = qres[SQ_STEPS][T_BITS-1:0];

endmodule

// ===== hw/rtl/inc_ratio.sv =====
// ----------------------------------------------------------------------------
// inc_ratio
// Evaluate both polynomials in t, then a restoring divide, one bit per stage.
// ----------------------------------------------------------------------------
module inc_ratio (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        vi,
  input  inc_pkg::side_t              si,
  input  logic [inc_pkg::T_BITS-1:0]  t,
  output logic                        vo,
  output inc_pkg::side_t              so,
  output logic [inc_pkg::T_BITS-1:0]  to,
  output logic [inc_pkg::R_BITS-1:0]  ratio
);
  import inc_pkg::*;

  logic [53:0] p_t2;
  logic [50:0] p_n1;
  logic [51:0] p_d1;
  logic [56:0] p_t3;
  logic [47:0] p_n2;
  logic [51:0] p_d2;
  logic [47:0] p_d3;

  logic        v1, v2, v3, v4;
  side_t       s1, s2, s3, s4;
  logic [T_BITS-1:0] t1, t2r, t3r, t4;
  logic [29:0] t2a;
  logic [26:0] n1a, n1b;
  logic [27:0] d1a, d1b;
  logic [32:0] t3a;
  logic [23:0] n2b;
  logic [27:0] d2b;
  logic [27:0] num3;
  logic [28:0] dsum3;
  logic [23:0] d3c;
  logic [27:0] num4;
  logic [28:0] den4;

  logic              dv [0:DIV_STEPS];
  side_t             ds [0:DIV_STEPS];
  logic [T_BITS-1:0] dt [0:DIV_STEPS];
  logic [28:0]       dd [0:DIV_STEPS];
  logic [51:0]       dr [0:DIV_STEPS];
  logic [R_BITS-1:0] dq [0:DIV_STEPS];

  assign p_t2 = t * t;
  assign p_n1 = t * C_N1;
  assign p_d1 = t * C_D1;
  assign p_t3 = t2a * t1;
  assign p_n2 = t2a * C_N2;
  assign p_d2 = t2a * C_D2;
  assign p_d3 = t3a * C_D3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= vi;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= si;
      t1    <= t;
      t2a   <= p_t2[53:24];
      n1a   <= p_n1[50:24];
      d1a   <= p_d1[51:24];
      s2    <= s1;
      t2r   <= t1;
      t3a   <= p_t3[56:24];
      n1b   <= n1a;
      d1b   <= d1a;
      n2b   <= p_n2[47:24];
      d2b   <= p_d2[51:24];
      s3    <= s2;
      t3r   <= t2r;
      num3  <= 28'(C_N0) + 28'(n1b) + 28'(n2b);
      dsum3 <= (29'(1) << IW) + 29'(d1b) + 29'(d2b);
      d3c   <= p_d3[47:24];
      s4    <= s3;
      t4    <= t3r;
      num4  <= num3;
      den4  <= dsum3 + 29'(d3c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds[0] <= s4;
      dt[0] <= t4;
      dd[0] <= den4;
      dr[0] <= {num4, 24'b0};
      dq[0] <= '0;
    end
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    logic [56:0] trial;
    logic        ge;
    assign trial = 57'(dd[g]) << (DIV_STEPS - 1 - g);
    assign ge    = 57'(dr[g]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[g+1] <= 1'b0;
      end else if (en) begin
        dv[g+1] <= dv[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ds[g+1] <= ds[g];
        dt[g+1] <= dt[g];
        dd[g+1] <= dd[g];
        dr[g+1] <= ge ? (dr[g] - trial[51:0]) : dr[g];
        dq[g+1] <= dq[g] | (R_BITS'(ge) << (DIV_STEPS - 1 - g));
      end
    end
  end

  assign vo    = dv[DIV_STEPS];
  assign so    = ds[DIV_STEPS];
  assign to    = dt[DIV_STEPS];
  assign ratio = dq[DIV_STEPS];

endmodule

// ===== hw/rtl/inverse_normal_cdf_approx_unit.sv =====
// ----------------------------------------------------------------------------
// inverse_normal_cdf_approx_unit
// Approximate standard-normal quantile of p = prob_code / 2^32, signed Q3.16.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_ready  prob_code[31:0]
//   output   out        out_valid/out_ready  quantile[19:0], saturated
//
// One transaction per cycle while the output is not stalled; stages are 26 log2 steps,
// 29 root steps, 33 polynomial and divide steps, one output stage.
// Reset clears every stage's valid bit; no data is cleared.
// A stall at the output freezes the whole pipeline; in_ready follows it.
// ----------------------------------------------------------------------------
module inverse_normal_cdf_approx_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [inc_pkg::PROB_BITS-1:0]  prob_code,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [inc_pkg::OUT_BITS-1:0] quantile,
  output logic                           saturated
);
  import inc_pkg::*;

  localparam int RND_SH = IW - FRAC_BITS;
  localparam logic signed [OUT_BITS-1:0] OMAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] OMIN = {1'b1, {(OUT_BITS-1){1'b0}}};

  logic              en;
  side_t             fs;
  logic [PROB_BITS-1:0] fx;
  logic              lv, qv, rv;
  side_t             ls, qs, rs;
  logic [Y_BITS-1:0] y;
  logic [T_BITS-1:0] t, rt;
  logic [R_BITS-1:0] ratio;
  logic              r_neg;
  logic [R_BITS-1:0] diff;
  logic [R_BITS:0]   rsum;
  logic [OUT_BITS:0] mag;
  logic              neg;
  logic signed [OUT_BITS-1:0] q_next;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign fs.neg  = !prob_code[PROB_BITS-1];
  assign fs.zero = prob_code == '0;
  assign fs.half = prob_code == (PROB_BITS'(1) << (PROB_BITS - 1));
  assign fx      = fs.neg ? prob_code : (~prob_code + PROB_BITS'(1));

  inc_log2 u_log2 (
    .clk (clk), .rst (rst), .en (en),
    .vi  (in_valid), .si (fs), .x (fx),
    .vo  (lv), .so (ls), .y (y)
  );

  inc_sqrt u_sqrt (
    .clk (clk), .rst (rst), .en (en),
    .vi  (lv), .si (ls), .y (y),
    .vo  (qv), .so (qs), .t (t)
  );

  inc_ratio u_ratio (
    .clk (clk), .rst (rst), .en (en),
    .vi  (qv), .si (qs), .t (t),
    .vo  (rv), .so (rs), .to (rt), .ratio (ratio)
  );

  always_comb begin
    r_neg = ratio > R_BITS'(rt);
    diff  = r_neg ? (ratio - R_BITS'(rt)) : (R_BITS'(rt) - ratio);
    rsum  = (R_BITS+1)'(diff) + (R_BITS+1)'(1 << (RND_SH - 1));
    mag   = (OUT_BITS+1)'(rsum >> RND_SH);
    neg   = r_neg ^ rs.neg;
    if (rs.zero) begin
      q_next = OMIN;
    end else if (rs.half) begin
      q_next = '0;
    end else if (neg) begin
      q_next = (mag > (OUT_BITS+1)'(1 << (OUT_BITS - 1))) ? OMIN : -mag[OUT_BITS-1:0];
    end else begin
      q_next = (mag > (OUT_BITS+1)'((1 << (OUT_BITS - 1)) - 1)) ? OMAX : mag[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= rv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quantile  <= q_next;
      saturated <= rs.zero;
    end
  end

endmodule
